[rtl/crc16lsb_pkg.sv]
// Shared types and constants for the LSB-first programmable CRC-16 engine.
// It has no dependencies. The configuration, update and top-level files use it.
`timescale 1ns / 1ps
`default_nettype none

package crc16lsb_pkg;

	localparam int CRC_W       = 16;
	localparam int BYTE_W      = 8;
	localparam int CFG_INDEX_W = 1;

	localparam logic [CRC_W-1:0] DEFAULT_POLY = 16'hE905;
	localparam logic [CRC_W-1:0] DEFAULT_INIT = 16'h0000;

	// Item operations. The fourth code is unused and leaves the CRC unchanged.
	typedef enum logic [1:0] {
		MODE_ABSORB  = 2'd0,
		MODE_LOAD    = 2'd1,
		MODE_RESTART = 2'd2
	} mode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_POLYNOMIAL    = 1'b0,
		REG_INITIAL_VALUE = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [CRC_W-1:0] polynomial;
		logic [CRC_W-1:0] initial_value;
	} cfg_t;

endpackage

`default_nettype wire

[rtl/crc16lsb_cfg.sv]
// Configuration register file that holds the polynomial and the initial value.
// It depends on crc16lsb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crc16lsb_cfg
	import crc16lsb_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CRC_W-1:0]       cfg_wdata,
	output cfg_t                        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.polynomial    <= DEFAULT_POLY;
			cfg_q.initial_value <= DEFAULT_INIT;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_POLYNOMIAL:    cfg_q.polynomial    <= cfg_wdata;
				REG_INITIAL_VALUE: cfg_q.initial_value <= cfg_wdata;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[rtl/crc16lsb_update.sv]
// Combinational next-state logic for the running CRC. It absorbs a byte, loads a value or restarts.
// It depends on crc16lsb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crc16lsb_update
	import crc16lsb_pkg::*;
(
	input  wire logic [CRC_W-1:0]  crc_cur,
	input  wire logic [1:0]        mode,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic [CRC_W-1:0]  load_value,
	input  wire cfg_t              cfg,
	output logic [CRC_W-1:0]       crc_next
);

	logic [CRC_W-1:0] absorbed;

	// Eight right shifts. Each step folds in the polynomial when a one drops out.
	always_comb begin
		logic [CRC_W-1:0] acc;
		acc = crc_cur ^ {{(CRC_W-BYTE_W){1'b0}}, data_byte};
		for (int i = 0; i < BYTE_W; i++) begin
			if (acc[0]) begin
				acc = (acc >> 1) ^ cfg.polynomial;
			end else begin
				acc = acc >> 1;
			end
		end
		absorbed = acc;
	end

	always_comb begin
		case (mode_t'(mode))
			MODE_ABSORB:  crc_next = absorbed;
			MODE_LOAD:    crc_next = load_value;
			MODE_RESTART: crc_next = cfg.initial_value;
			default:      crc_next = crc_cur;
		endcase
	end

endmodule

`default_nettype wire

[rtl/crc16_lsb_first_programmable.sv]
// Top level of the byte-wide LSB-first CRC-16 engine with a programmable polynomial.
// It depends on crc16lsb_pkg, crc16lsb_cfg and crc16lsb_update.
`timescale 1ns / 1ps
`default_nettype none

//  channel   direction  handshake           payload
//  in        request in  in_valid/in_stall   mode, data_byte, load_value
//  out       result out  out_valid/out_stall crc_out
//  cfg       write in    cfg_we              cfg_index, cfg_wdata
//
// The engine takes one request per cycle while in_stall is low. The limit comes from
// the single running-CRC register, which is updated once per request.
// A request is held in the input register, and its update is then computed into
// the result register.
// The result register also holds the running CRC. Reset clears it to zero,
// sets the polynomial to 0xE905 and the initial value to zero.
// A stall on the output holds the result. The input register can still take a new
// request while the result waits. Only when both registers are full does in_stall
// rise, and then it follows out_stall.

module crc16_lsb_first_programmable
	import crc16lsb_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [1:0]             mode,
	input  wire logic [BYTE_W-1:0]      data_byte,
	input  wire logic [CRC_W-1:0]       load_value,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [CRC_W-1:0]            crc_out,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CRC_W-1:0]       cfg_wdata
);

	cfg_t cfg;

	// Input register. It holds one request waiting for its update.
	logic              valid_s1;
	logic [1:0]        mode_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [CRC_W-1:0]  load_s1;

	// The result register, which is also the running CRC.
	logic             out_valid_q;
	logic [CRC_W-1:0] crc_q;
	logic [CRC_W-1:0] crc_next;

	logic s1_move;
	logic in_take;

	crc16lsb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	crc16lsb_update u_update (
		.crc_cur    (crc_q),
		.mode       (mode_s1),
		.data_byte  (byte_s1),
		.load_value (load_s1),
		.cfg        (cfg),
		.crc_next   (crc_next)
	);

	// The held request moves on whenever the result slot is empty or is being drained.
	assign s1_move  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_move;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_s1 <= mode;
			byte_s1 <= data_byte;
			load_s1 <= load_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			crc_q       <= '0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
			crc_q       <= crc_next;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign crc_out   = crc_q;

	// A load request puts its value into the CRC exactly.
	a_load_exact: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_move && mode_s1 == MODE_LOAD) |=> (crc_q == $past(load_s1)))
		else $error("load request did not set the running CRC");

	// The unused code leaves the running CRC untouched.
	a_unused_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_move && mode_s1 != MODE_ABSORB && mode_s1 != MODE_LOAD
			&& mode_s1 != MODE_RESTART) |=> $stable(crc_q))
		else $error("unused mode changed the running CRC");

	// Input back-pressure only appears when both registers are full and the output is stalled.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a full pipeline");

	// The CRC changes only when a request moves into the result register.
	a_crc_only_on_move: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_move |=> $stable(crc_q))
		else $error("running CRC changed without a request");

endmodule

`default_nettype wire
